@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define ASSERT_HOLDS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/wms_pkg.sv @@
// ----------------------------------------------------------------------------
// wms_pkg
// Shared types and constants of the wildcard match stream unit.
// ----------------------------------------------------------------------------
package wms_pkg;

  localparam int PAT_LEN_DEF = 64;
  localparam int SYM_W       = 8;

  localparam logic [SYM_W-1:0] SYM_STAR = 8'h2A;  // any run of bytes
  localparam logic [SYM_W-1:0] SYM_ANY  = 8'h3F;  // any single byte

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_END    = 2'd3
  } cmd_t;

  // Request from the command stage to the pattern store
  typedef struct packed {
    logic             clear;
    logic             append;
    logic [SYM_W-1:0] symbol;
  } store_op_t;

endpackage

@@ rtl/wms_pattern_store.sv @@
// ----------------------------------------------------------------------------
// wms_pattern_store
// Pattern bytes, fill count, empty-text row and overflow flag.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wms_pattern_store import wms_pkg::*; #(
  parameter  int PAT_LEN = PAT_LEN_DEF,
  localparam int CW      = $clog2(PAT_LEN + 1),
  localparam int IW      = (PAT_LEN > 1) ? $clog2(PAT_LEN) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  store_op_t                       op,
  output logic [PAT_LEN-1:0][SYM_W-1:0]   pattern,
  output logic [CW-1:0]                   count,
  output logic [PAT_LEN:0]                empty_row,
  output logic [PAT_LEN:0]                empty_row_next,
  output logic                            stored,
  output logic                            overflow
);

  logic          has_room;
  logic          sym_star;
  logic [CW-1:0] count_next;
  logic          overflow_next;

  assign has_room = (count < CW'(PAT_LEN));
  assign sym_star = (op.symbol == SYM_STAR);
  assign stored   = op.append & has_room;

  // Next state: clear, extend the empty-text row by one pattern position, or flag overflow
  always_comb begin
    empty_row_next = empty_row;
    count_next     = count;
    overflow_next  = overflow;
    if (op.clear) begin
      empty_row_next = {{PAT_LEN{1'b0}}, 1'b1};
      count_next     = '0;
      overflow_next  = 1'b0;
    end else if (stored) begin
      empty_row_next[count + CW'(1)] = empty_row[count] & sym_star;
      count_next = count + CW'(1);
    end else if (op.append) begin
      overflow_next = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      empty_row <= {{PAT_LEN{1'b0}}, 1'b1};
      count     <= '0;
      overflow  <= 1'b0;
    end else begin
      empty_row <= empty_row_next;
      count     <= count_next;
      overflow  <= overflow_next;
    end
  end

  // Pattern bytes, written at the fill count
  always_ff @(posedge clk) begin
    if (stored) begin
      pattern[count[IW-1:0]] <= op.symbol;
    end
  end

  `ASSERT_IMPLIES(a_ovf_only_when_full, clk, rst, overflow, count == CW'(PAT_LEN),
    "overflow flagged while pattern store not full")
  `ASSERT_HOLDS(a_empty_row_clear_above, clk, rst, ((empty_row >> count) >> 1) == '0,
    "empty-text row set above fill count")

endmodule

@@ rtl/wms_row_scan.sv @@
// ----------------------------------------------------------------------------
// wms_row_scan
// Next match row for one text byte: per-lane terms and a prefix OR scan.
// ----------------------------------------------------------------------------
module wms_row_scan import wms_pkg::*; #(
  parameter  int PAT_LEN = PAT_LEN_DEF,
  localparam int CW      = $clog2(PAT_LEN + 1),
  localparam int LVL     = $clog2(PAT_LEN + 1)
) (
  input  logic [PAT_LEN:0]                row,
  input  logic [PAT_LEN-1:0][SYM_W-1:0]   pattern,
  input  logic [CW-1:0]                   count,
  input  logic [SYM_W-1:0]                symbol,
  output logic [PAT_LEN:0]                row_next
);

  logic                       c_star;
  logic                       c_any;
  logic [PAT_LEN:0]           gen;
  logic [PAT_LEN:0]           prop;
  logic [LVL:0][PAT_LEN:0]    gs;
  logic [LVL:0][PAT_LEN:0]    ps;

  assign c_star = (symbol == SYM_STAR);
  assign c_any  = (symbol == SYM_ANY);

  // Per-lane generate and propagate terms; lanes above the count stay clear
  always_comb begin
    logic lane_on;
    logic star;
    logic one;
    gen[0]  = row[0] & c_star;
    prop[0] = 1'b0;
    for (int j = 1; j <= PAT_LEN; j++) begin
      lane_on = (CW'(j) <= count);
      star    = c_star | (pattern[j-1] == SYM_STAR);
      one     = c_any | (pattern[j-1] == SYM_ANY) | (pattern[j-1] == symbol);
      gen[j]  = lane_on & (star ? row[j] : (one & row[j-1]));
      prop[j] = lane_on & star;
    end
  end

  // Prefix scan: a star lane takes the new value of its left neighbour
  always_comb begin
    gs[0] = gen;
    ps[0] = prop;
    for (int k = 0; k < LVL; k++) begin
      for (int j = 0; j <= PAT_LEN; j++) begin
        if (j >= (1 << k)) begin
          gs[k+1][j] = gs[k][j] | (ps[k][j] & gs[k][j - (1 << k)]);
          ps[k+1][j] = ps[k][j] & ps[k][j - (1 << k)];
        end else begin
          gs[k+1][j] = gs[k][j];
          ps[k+1][j] = ps[k][j];
        end
      end
    end
  end

  assign row_next = gs[LVL];

endmodule

@@ rtl/wildcard_match_stream_unit.sv @@
// ----------------------------------------------------------------------------
// wildcard_match_stream_unit
// Streaming wildcard matcher: loads a pattern, matches a text byte per beat.
// ----------------------------------------------------------------------------
// Channel | Dir | tdata                         | tuser
// s_*     | in  | [7:0] symbol                  | [1:0] cmd (clear/append/text/end)
// m_*     | out | [0] matched, [1] overflowed   | -
//
// One beat per cycle is accepted unless an end-of-text beat stalls; each beat
// is registered, then applied to the match row by a single combinational
// pass (per-lane compare plus a log2(PAT_LEN+1)-level prefix OR). The verdict
// of an end beat passes the input and result registers to m_*; only end
// beats wait for a full result register, others go on under output stall.
// Reset is synchronous and needs no clearing pass; pattern bytes are unreset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wildcard_match_stream_unit import wms_pkg::*; #(
  parameter  int PAT_LEN = PAT_LEN_DEF,
  localparam int CW      = $clog2(PAT_LEN + 1)
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] symbol
  input  logic [1:0] s_tuser,   // [1:0] cmd
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] matched, [1] overflowed, [7:2] zero
);

  logic                          in_valid;
  cmd_t                          in_cmd;
  logic [SYM_W-1:0]              in_sym;
  logic                          out_free;
  logic                          fire;
  logic                          end_fire;
  store_op_t                     op;
  logic [PAT_LEN-1:0][SYM_W-1:0] pattern;
  logic [CW-1:0]                 count;
  logic [PAT_LEN:0]              empty_row;
  logic [PAT_LEN:0]              empty_row_next;
  logic                          stored;
  logic                          overflow;
  logic [PAT_LEN:0]              match_row;
  logic [PAT_LEN:0]              match_row_next;
  logic [PAT_LEN:0]              scan_row;
  logic                          matched;
  logic                          overflowed;

  // Handshake: advance the input register whenever its beat is applied
  assign out_free = ~m_tvalid | m_tready;
  assign fire     = in_valid & ((in_cmd != CMD_END) | out_free);
  assign end_fire = fire & (in_cmd == CMD_END);
  assign s_tready = ~in_valid | fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  // Input payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd <= cmd_t'(s_tuser);
      in_sym <= s_tdata;
    end
  end

  // Pattern side
  assign op.clear  = fire & (in_cmd == CMD_CLEAR);
  assign op.append = fire & (in_cmd == CMD_APPEND);
  assign op.symbol = in_sym;

  wms_pattern_store #(.PAT_LEN(PAT_LEN)) u_store (
    .clk            (clk),
    .rst            (rst),
    .op             (op),
    .pattern        (pattern),
    .count          (count),
    .empty_row      (empty_row),
    .empty_row_next (empty_row_next),
    .stored         (stored),
    .overflow       (overflow)
  );

  wms_row_scan #(.PAT_LEN(PAT_LEN)) u_scan (
    .row      (match_row),
    .pattern  (pattern),
    .count    (count),
    .symbol   (in_sym),
    .row_next (scan_row)
  );

  // Select the next match row by command
  always_comb begin
    match_row_next = match_row;
    if (fire) begin
      case (in_cmd)
        CMD_CLEAR:  match_row_next = {{PAT_LEN{1'b0}}, 1'b1};
        CMD_APPEND: if (stored) begin
                      match_row_next = empty_row_next;
                    end
        CMD_TEXT:   match_row_next = scan_row;
        CMD_END:    match_row_next = empty_row;
        default:    match_row_next = match_row;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_row <= {{PAT_LEN{1'b0}}, 1'b1};
    end else begin
      match_row <= match_row_next;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (end_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (end_fire) begin
      matched    <= match_row[count];
      overflowed <= overflow;
    end
  end

  assign m_tdata = {6'b0, overflowed, matched};

  `ASSERT_HOLDS(a_row_clear_above, clk, rst, ((match_row >> count) >> 1) == '0,
    "match row set above fill count")
  `ASSERT_NEXT(a_end_restores_row, clk, rst, end_fire, match_row == empty_row,
    "end of text did not restore the empty-text row")

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wildcard match stream unit. Pattern and text
// beats go in on the slave stream, with random gaps and bursts. A bit-row
// predictor of the wildcard table gives the expected verdict of each
// end-of-text beat. Each verdict on the master stream is checked field by
// field, under random output stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import wms_pkg::*;

  localparam int PAT_CAP    = PAT_LEN_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int ITEM_GOAL  = 1050;

  typedef struct {
    logic matched;
    logic overflowed;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] symbol
  logic [1:0] s_tuser = 2'b00;   // [1:0] cmd
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [0] matched, [1] overflowed, [7:2] zero

  // Predictor state: pattern, current row, empty-text row, overflow flag
  logic [7:0]     pat_bytes [PAT_CAP];
  int             pat_len;
  logic [PAT_CAP:0] cur_row;
  logic [PAT_CAP:0] empty_row;
  logic           ovf_seen;

  verdict_t pending_verdicts[$];

  int  err_count   = 0;
  int  beats_sent  = 0;
  int  verdicts_in = 0;
  int  hits_in     = 0;
  int  ovf_in      = 0;
  int  idle_cycles = 0;
  bit  calm        = 1'b0;

  wildcard_match_stream_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Bring both rows back to the empty-pattern state
  function automatic void rows_home();
    cur_row      = '0;
    empty_row    = '0;
    cur_row[0]   = 1'b1;
    empty_row[0] = 1'b1;
  endfunction

  // Advance the row by one text byte, lowest pattern position first
  function automatic void advance_row(logic [7:0] c);
    logic diag;
    logic above;
    logic nxt;
    logic [7:0] p;
    diag = cur_row[0];
    cur_row[0] = cur_row[0] && (c == SYM_STAR);
    for (int j = 1; j <= pat_len; j++) begin
      p     = pat_bytes[j-1];
      above = cur_row[j];
      if (c == SYM_STAR || p == SYM_STAR) begin
        nxt = above | cur_row[j-1];
      end else if (c == SYM_ANY || p == SYM_ANY) begin
        nxt = diag;
      end else begin
        nxt = (c == p) && diag;
      end
      diag       = above;
      cur_row[j] = nxt;
    end
  endfunction

  // Apply one accepted beat to the predicted matcher state
  function automatic void track_matcher(cmd_t c, logic [7:0] sym);
    verdict_t v;
    case (c)
      CMD_CLEAR: begin
        pat_len  = 0;
        ovf_seen = 1'b0;
        rows_home();
      end
      CMD_APPEND: begin
        if (pat_len >= PAT_CAP) begin
          ovf_seen = 1'b1;
        end else begin
          pat_bytes[pat_len]   = sym;
          empty_row[pat_len+1] = empty_row[pat_len] && (sym == SYM_STAR);
          pat_len++;
          cur_row = empty_row;
        end
      end
      CMD_TEXT: begin
        advance_row(sym);
      end
      default: begin
        v.matched    = cur_row[pat_len];
        v.overflowed = ovf_seen;
        pending_verdicts.push_back(v);
        cur_row = empty_row;
      end
    endcase
  endfunction

  // Drive one beat after a random gap and hold it until accepted
  task automatic send_beat(cmd_t c, logic [7:0] sym);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c;
    s_tdata  <= sym;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    track_matcher(c, sym);
    beats_sent++;
  endtask

  // Drop valid and hold off until every verdict has come back
  task automatic drain_verdicts();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_verdicts.size() > 0) @(posedge clk);
  endtask

  // Mostly a small alphabet with wildcards, sometimes any byte
  function automatic logic [7:0] pick_symbol();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return SYM_STAR;
    if (r == 2) return SYM_ANY;
    if (r < 7) return 8'h61 + 8'($urandom_range(0, 1));
    if (r < 9) return 8'h61 + 8'($urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  // Extremes, each command, wildcards on both sides, restarts and ignored symbols
  task automatic test_directed();
    calm = 1'b0;
    send_beat(CMD_END, 8'h00);
    send_beat(CMD_TEXT, 8'h41);
    send_beat(CMD_END, 8'hFF);
    send_beat(CMD_CLEAR, 8'hFF);
    send_beat(CMD_APPEND, 8'h00);
    send_beat(CMD_APPEND, 8'hFF);
    send_beat(CMD_TEXT, 8'h00);
    send_beat(CMD_TEXT, 8'hFF);
    send_beat(CMD_END, 8'h00);
    // append mid-text discards the text so far
    send_beat(CMD_TEXT, 8'h00);
    send_beat(CMD_APPEND, SYM_STAR);
    send_beat(CMD_TEXT, 8'h00);
    send_beat(CMD_TEXT, 8'hFF);
    send_beat(CMD_TEXT, 8'h12);
    send_beat(CMD_END, 8'h00);
    send_beat(CMD_TEXT, SYM_STAR);
    send_beat(CMD_END, 8'h00);
    send_beat(CMD_CLEAR, 8'h00);
    send_beat(CMD_APPEND, SYM_ANY);
    send_beat(CMD_APPEND, 8'h62);
    send_beat(CMD_TEXT, SYM_ANY);
    send_beat(CMD_TEXT, SYM_STAR);
    send_beat(CMD_TEXT, 8'h63);
    // clear mid-text drops both the pattern and the text
    send_beat(CMD_CLEAR, 8'h55);
    send_beat(CMD_END, 8'hAA);
  endtask

  // Fill the pattern to capacity, push past it, and check the flag sticks
  task automatic test_pattern_full();
    calm = 1'b1;
    send_beat(CMD_CLEAR, 8'h00);
    for (int i = 0; i < PAT_CAP; i++) send_beat(CMD_APPEND, SYM_ANY);
    send_beat(CMD_END, 8'h00);
    for (int i = 0; i < PAT_CAP; i++) send_beat(CMD_TEXT, 8'($urandom_range(0, 255)));
    send_beat(CMD_END, 8'h00);
    send_beat(CMD_APPEND, 8'h78);
    send_beat(CMD_APPEND, 8'h79);
    for (int i = 0; i < PAT_CAP; i++) send_beat(CMD_TEXT, 8'h61);
    send_beat(CMD_END, 8'h00);
    send_beat(CMD_END, 8'h00);
    calm = 1'b0;
    send_beat(CMD_CLEAR, 8'h00);
    for (int i = 0; i < PAT_CAP + 3; i++) send_beat(CMD_APPEND, pick_symbol());
    for (int i = 0; i < 20; i++) send_beat(CMD_TEXT, pick_symbol());
    send_beat(CMD_END, 8'h00);
    send_beat(CMD_CLEAR, 8'h00);
    send_beat(CMD_END, 8'h00);
  endtask

  // Send a short burst and let the output side empty completely
  task automatic test_drain_pause();
    calm = 1'b1;
    send_beat(CMD_CLEAR, 8'h00);
    send_beat(CMD_APPEND, SYM_STAR);
    send_beat(CMD_END, 8'h00);
    send_beat(CMD_TEXT, 8'h61);
    send_beat(CMD_END, 8'h00);
    drain_verdicts();
    calm = 1'b0;
  endtask

  // Well-formed pattern/text sessions with random content, plus noise
  task automatic test_random_sessions();
    int n_pat;
    int n_txt;
    int n_texts;
    int r;
    while (beats_sent < ITEM_GOAL) begin
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 19) == 0) drain_verdicts();
      if ($urandom_range(0, 7) == 0) begin
        // noise: any command, any byte
        repeat ($urandom_range(1, 6))
          send_beat(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          send_beat(CMD_CLEAR, 8'($urandom_range(0, 255)));
          n_pat = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 70)
                                               : $urandom_range(0, 8);
          repeat (n_pat) send_beat(CMD_APPEND, pick_symbol());
        end
        n_texts = $urandom_range(1, 3);
        repeat (n_texts) begin
          n_txt = $urandom_range(0, 12);
          for (int i = 0; i < n_txt; i++) begin
            r = $urandom_range(0, 39);
            if (r == 0) begin
              send_beat(CMD_APPEND, pick_symbol());
            end else if (r == 1) begin
              send_beat(CMD_CLEAR, 8'($urandom_range(0, 255)));
            end else begin
              send_beat(CMD_TEXT, pick_symbol());
            end
          end
          send_beat(CMD_END, 8'($urandom_range(0, 255)));
        end
      end
    end
    calm = 1'b0;
  endtask

  // Result side: random stall before each verdict beat, with calm stretches
  initial begin : result_sink
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Compare each verdict beat with the oldest prediction
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected verdict beat, tdata %02h", m_tdata);
        err_count++;
      end else begin
        want = pending_verdicts.pop_front();
        verdicts_in++;
        if (m_tdata[0]) hits_in++;
        if (m_tdata[1]) ovf_in++;
        if (m_tdata[0] !== want.matched) begin
          $error("matched: expected %0b, got %0b", want.matched, m_tdata[0]);
          err_count++;
        end
        if (m_tdata[1] !== want.overflowed) begin
          $error("overflowed: expected %0b, got %0b", want.overflowed, m_tdata[1]);
          err_count++;
        end
        if (m_tdata[7:2] !== 6'd0) begin
          $error("pad: expected 0, got %02h", m_tdata[7:2]);
          err_count++;
        end
      end
    end
  end

  // Stop the run when neither side moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("Timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    pat_len  = 0;
    ovf_seen = 1'b0;
    rows_home();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_pattern_full();
    test_drain_pause();
    test_random_sessions();

    drain_verdicts();
    repeat (8) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      $error("%0d verdicts never arrived", pending_verdicts.size());
      err_count++;
    end

    $display("Sent %0d beats over all commands; checked %0d verdicts", beats_sent,
             verdicts_in);
    $display("Verdicts with a match: %0d, with pattern overflow: %0d", hits_in, ovf_in);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
